// ===== sv/upq_pkg.sv =====
// Shared command/status codes and controller command bundle for the priority queue.
package upq_pkg;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam int KEY_W = 8;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;

	typedef struct packed {
		logic capture;  // latch incoming item
		logic compare;  // register per-cell key/priority compares
		logic commit;   // apply update and load result register
	} upq_cmd_t;

endpackage

// ===== sv/upq_ctrl.sv =====
// Sequencer for the priority queue: accept, compare, commit, result handshake.
module upq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output upq_pkg::upq_cmd_t cmd
);
	import upq_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		CMP,
		COMMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   mvalid_q;

	assign s_tready    = ready_q;
	assign m_tvalid    = mvalid_q;
	assign cmd.capture = s_tvalid && ready_q;
	assign cmd.compare = (state_q == CMP);
	// result slot must be free (or draining this cycle) before commit
	assign cmd.commit  = (state_q == COMMIT) && (!mvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			ready_q  <= 1'b1;
			mvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd.capture) begin
						state_q <= CMP;
						ready_q <= 1'b0;
					end
				end
				CMP: begin
					state_q <= COMMIT;
				end
				COMMIT: begin
					if (cmd.commit) begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
					ready_q <= 1'b1;
				end
			endcase
			if (cmd.commit) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/upq_datapath.sv =====
// Shift-register cell array, per-cell compares and result register of the priority queue.
module upq_datapath #(
	parameter int DEPTH      = 16,
	parameter int PRIO_WIDTH = 16,
	parameter int CNT_W      = $clog2(DEPTH + 1),
	parameter int IN_W       = ((upq_pkg::CMD_W + upq_pkg::KEY_W + PRIO_WIDTH + 7) / 8) * 8,
	parameter int OUT_W      = ((upq_pkg::STS_W + upq_pkg::KEY_W + PRIO_WIDTH + CNT_W + 7)
		/ 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  upq_pkg::upq_cmd_t cmd,
	input  logic [IN_W-1:0]   s_tdata,
	output logic [OUT_W-1:0]  m_tdata
);
	import upq_pkg::*;

	localparam int PRIO_LO = CMD_W + KEY_W;
	localparam int RES_W   = STS_W + KEY_W + PRIO_WIDTH + CNT_W;

	// captured item
	logic [CMD_W-1:0]             cmd_s1;
	logic [KEY_W-1:0]             key_s1;
	logic signed [PRIO_WIDTH-1:0] prio_s1;

	// cells, head at index 0
	logic [KEY_W-1:0]             key_q  [DEPTH];
	logic signed [PRIO_WIDTH-1:0] prio_q [DEPTH];
	logic [CNT_W-1:0]             count_q;

	// per-cell compare flags
	logic [DEPTH-1:0] hit_s2;
	logic [DEPTH-1:0] gt_s2;

	// result register
	logic [STS_W-1:0]             sts_q;
	logic [KEY_W-1:0]             okey_q;
	logic [PRIO_WIDTH-1:0]        oprio_q;
	logic [CNT_W-1:0]             fill_q;

	logic dup;
	logic full;
	logic empty;
	logic push_ok;
	logic pop_ok;

	assign dup     = |hit_s2;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = (cmd_s1 == CMD_PUSH) && !dup && !full;
	assign pop_ok  = (cmd_s1 == CMD_POP) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1  <= s_tdata[CMD_W-1:0];
			key_s1  <= s_tdata[CMD_W +: KEY_W];
			prio_s1 <= s_tdata[PRIO_LO +: PRIO_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				hit_s2[i] <= (CNT_W'(i) < count_q) && (key_q[i] == key_s1);
				gt_s2[i]  <= (CNT_W'(i) < count_q) && (prio_q[i] > prio_s1);
			end
		end
	end

	// gt_s2 is a prefix since cells are sorted; the new entry lands at the first clear bit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (push_ok) begin
				if (!gt_s2[0]) begin
					key_q[0]  <= key_s1;
					prio_q[0] <= prio_s1;
				end
				for (int i = 1; i < DEPTH; i++) begin
					if (!gt_s2[i]) begin
						if (gt_s2[i-1]) begin
							key_q[i]  <= key_s1;
							prio_q[i] <= prio_s1;
						end else begin
							key_q[i]  <= key_q[i-1];
							prio_q[i] <= prio_q[i-1];
						end
					end
				end
			end else if (pop_ok) begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					key_q[i]  <= key_q[i+1];
					prio_q[i] <= prio_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			if (push_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sts_q   <= ST_OK;
			okey_q  <= '0;
			oprio_q <= '0;
			fill_q  <= count_q;
			case (cmd_s1)
				CMD_PUSH: begin
					if (dup) begin
						sts_q <= ST_DUP;
					end else if (full) begin
						sts_q <= ST_FULL;
					end else begin
						fill_q <= count_q + 1'b1;
					end
				end
				CMD_POP, CMD_PEEK: begin
					if (empty) begin
						sts_q <= ST_EMPTY;
					end else begin
						okey_q  <= key_q[0];
						oprio_q <= prio_q[0];
						if (cmd_s1 == CMD_POP) begin
							fill_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	logic [RES_W-1:0] res;
	assign res     = {fill_q, oprio_q, okey_q, sts_q};
	assign m_tdata = OUT_W'(res);

endmodule

// ===== sv/unique_key_priority_queue.sv =====
// After the input accept, a compare step and then a commit step produce the result.
// A new item is accepted only once the previous one has committed; a held result
// stalls the commit step until it is taken. Compares run over all cells in parallel.
// Reset (arst_n low, asynchronous): queue empty, input ready, no result pending.
// Cell contents are not cleared; only cells below the fill count are ever used.
module unique_key_priority_queue #(
	parameter int DEPTH      = 16,
	parameter int PRIO_WIDTH = 16,
	parameter int CNT_W      = $clog2(DEPTH + 1),
	parameter int IN_W       = ((upq_pkg::CMD_W + upq_pkg::KEY_W + PRIO_WIDTH + 7) / 8) * 8,
	parameter int OUT_W      = ((upq_pkg::STS_W + upq_pkg::KEY_W + PRIO_WIDTH + CNT_W + 7)
		/ 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // command, key_id, prio_in, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status, out_key, out_prio, fill_level, zero pad
);
	import upq_pkg::*;

	upq_cmd_t cmd;

	upq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	upq_datapath #(
		.DEPTH      (DEPTH),
		.PRIO_WIDTH (PRIO_WIDTH),
		.CNT_W      (CNT_W),
		.IN_W       (IN_W),
		.OUT_W      (OUT_W)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule
